/* sv/lsq_pkg.sv */
// Shared definitions for the linear-scan priority queue.
// Holds the default capacity, field widths, and the mode and result status codes.
// No dependencies.
`default_nettype none

package lsq_pkg;

	localparam int LSQ_CAPACITY = 16;
	localparam int PRIO_W       = 16;
	localparam int DATA_W       = 32;
	localparam int OCC_W        = 5;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} lsq_status_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} lsq_mode_t;

endpackage

`default_nettype wire

/* sv/linear_scan_priority_queue.sv */
// Insert: result is registered in the cycle after the transaction; one item per cycle while idle and not stalled.
// Remove from an empty queue: also registered in the cycle after the transaction.
// Remove: the single memory read port scans one slot per cycle
// and the freed slot is refilled with the last entry in a final write cycle.
// Reset (arst_n low) empties the queue; slot contents are not cleared.
// Built on lsq_pkg; entries live in one internal memory with a registered read.
`default_nettype none

module linear_scan_priority_queue
	import lsq_pkg::*;
#(
	parameter int CAPACITY = LSQ_CAPACITY
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     mode,
	input  wire logic signed [PRIO_W-1:0] priority_req,
	input  wire logic signed [DATA_W-1:0] payload,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      removed_data,
	output logic [OCC_W-1:0]              occupancy
);

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WORD_W = PRIO_W + DATA_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         scan_q;
	logic [CNT_W-1:0]         last_cnt;

	logic [WORD_W-1:0]        mem_q [CAPACITY];
	logic [WORD_W-1:0]        rd_word_s1;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic [IDX_W-1:0]         rd_addr;

	logic signed [PRIO_W-1:0] best_prio_q;
	logic [DATA_W-1:0]        best_data_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [WORD_W-1:0]        last_word_q;
	logic signed [PRIO_W-1:0] rd_prio;

	logic                     out_valid_q;
	lsq_status_t              status_q;
	logic [DATA_W-1:0]        removed_q;
	logic [OCC_W-1:0]         occ_q;

	logic out_free;
	logic in_accept;
	logic do_insert;
	logic start_scan;
	logic scan_issue;
	logic finish;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != S_IDLE) || !out_free;
	assign in_accept  = in_valid && !in_stall;
	assign do_insert  = in_accept && (mode == MODE_INSERT) && (count_q != FULL_CNT);
	assign start_scan = in_accept && (mode == MODE_REMOVE) && (count_q != '0);
	assign scan_issue = (state_q == S_SCAN) && (scan_q < count_q);
	assign finish     = (state_q == S_DONE) && out_free;
	assign last_cnt   = CNT_W'(count_q - 1'b1);
	assign rd_addr    = (state_q == S_SCAN) ? scan_q[IDX_W-1:0] : '0;
	assign rd_prio    = rd_word_s1[WORD_W-1 -: PRIO_W];

	// Entry storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (do_insert) begin
			mem_q[count_q[IDX_W-1:0]] <= {priority_req, payload};
		end else if (finish) begin
			mem_q[best_idx_q] <= last_word_q;
		end
		rd_word_s1 <= mem_q[rd_addr];
		rd_idx_s1  <= rd_addr;
	end

	// Running maximum; the first slot seeds it and only a strictly greater
	// priority replaces it, so the lowest slot wins ties.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (state_q == S_SCAN)) begin
			if ((rd_idx_s1 == '0) || (rd_prio > best_prio_q)) begin
				best_prio_q <= rd_prio;
				best_data_q <= rd_word_s1[DATA_W-1:0];
				best_idx_q  <= rd_idx_s1;
			end
			last_word_q <= rd_word_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= start_scan || scan_issue;
			case (state_q)
				S_IDLE: begin
					if (do_insert) begin
						count_q <= CNT_W'(count_q + 1'b1);
					end
					if (start_scan) begin
						scan_q  <= CNT_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						scan_q <= CNT_W'(scan_q + 1'b1);
					end
					if (rd_vld_s1 && (CNT_W'(rd_idx_s1) == last_cnt)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q <= last_cnt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register; a new result loads only once the previous transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish || (in_accept && !start_scan)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q  <= ST_REMOVED;
			removed_q <= best_data_q;
			occ_q     <= OCC_W'(last_cnt);
		end else if (in_accept && !start_scan) begin
			removed_q <= '0;
			if (mode == MODE_REMOVE) begin
				status_q <= ST_EMPTY;
				occ_q    <= '0;
			end else if (do_insert) begin
				status_q <= ST_INSERTED;
				occ_q    <= OCC_W'(count_q + 1'b1);
			end else begin
				status_q <= ST_DROPPED;
				occ_q    <= OCC_W'(count_q);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign removed_data = removed_q;
	assign occupancy    = occ_q;

endmodule

`default_nettype wire

/* dv/lsq_checker.sv */
// Scoreboard for the linear-scan priority queue: watches both channels,
// predicts each result from its own copy of the queue and compares field by field.
// Depends on lsq_pkg for widths and the mode and status codes.
module lsq_checker
	import lsq_pkg::*;
#(
	parameter int CAPACITY = LSQ_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     mode,
	input  logic signed [PRIO_W-1:0] priority_req,
	input  logic signed [DATA_W-1:0] payload,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [1:0]               status,
	input  logic signed [DATA_W-1:0] removed_data,
	input  logic [OCC_W-1:0]         occupancy,
	output int                       mismatches,
	output int                       outstanding,
	output int                       results_checked,
	output int                       full_drops,
	output int                       empty_removes,
	output int                       peak_fill
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		lsq_status_t             st;
		logic signed [DATA_W-1:0] data;
		logic [OCC_W-1:0]         occ;
	} pq_result_t;

	// Shadow copy of the queue; slots past held_count are never read.
	logic signed [PRIO_W-1:0] held_prio [CAPACITY];
	logic signed [DATA_W-1:0] held_data [CAPACITY];
	int held_count = 0;

	pq_result_t awaited_q [$];
	int n_bad     = 0;
	int n_pending = 0;
	int n_checked = 0;
	int n_drops   = 0;
	int n_empty   = 0;
	int n_peak    = 0;

	assign mismatches      = n_bad;
	assign outstanding     = n_pending;
	assign results_checked = n_checked;
	assign full_drops      = n_drops;
	assign empty_removes   = n_empty;
	assign peak_fill       = n_peak;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%h, expected 0x%h", $realtime, what, got, want);
		n_bad++;
	endtask

	function automatic pq_result_t apply_queue_op(input lsq_mode_t op,
		input logic signed [PRIO_W-1:0] prio, input logic signed [DATA_W-1:0] data);
		pq_result_t r;
		int best;
		r.data = '0;
		if (op == MODE_INSERT) begin
			if (held_count < CAPACITY) begin
				held_prio[held_count] = prio;
				held_data[held_count] = data;
				held_count++;
				r.st = ST_INSERTED;
			end else begin
				r.st = ST_DROPPED;
			end
		end else if (held_count == 0) begin
			r.st = ST_EMPTY;
		end else begin
			// Strict greater-than keeps the lowest slot on equal priorities.
			best = 0;
			for (int i = 1; i < held_count; i++)
				if (held_prio[i] > held_prio[best])
					best = i;
			r.data = held_data[best];
			held_prio[best] = held_prio[held_count-1];
			held_data[best] = held_data[held_count-1];
			held_count--;
			r.st = ST_REMOVED;
		end
		r.occ = OCC_W'(held_count);
		return r;
	endfunction

	always @(posedge clk) begin
		pq_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (awaited_q.size() == 0) begin
					report_mismatch("unexpected result (status)", 32'(status), 32'hffff_ffff);
				end else begin
					want = awaited_q.pop_front();
					if (status != want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (removed_data != want.data)
						report_mismatch("removed_data", removed_data, want.data);
					if (occupancy != want.occ)
						report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_queue_op(lsq_mode_t'(mode), priority_req, payload);
				if (want.st == ST_DROPPED)
					n_drops++;
				if (want.st == ST_EMPTY)
					n_empty++;
				if (held_count > n_peak)
					n_peak = held_count;
				awaited_q.push_back(want);
			end
			n_pending <= awaited_q.size();
		end
	end

endmodule

/* dv/tb.sv */
// Top of the priority queue testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Instantiates linear_scan_priority_queue beside lsq_checker;
// depends on lsq_pkg.
module tb
	import lsq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY       = LSQ_CAPACITY;
	localparam int RANDOM_OPS     = 1700;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = CAPACITY + 6;

	typedef enum int {
		PRIO_WIDE,
		PRIO_NARROW,
		PRIO_EDGE
	} prio_style_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic                     mode         = MODE_INSERT;
	logic signed [PRIO_W-1:0] priority_req = '0;
	logic signed [DATA_W-1:0] payload      = '0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] removed_data;
	logic [OCC_W-1:0]         occupancy;

	int mismatches, outstanding, results_checked, full_drops, empty_removes, peak_fill;

	// When set, neither side inserts gaps or stalls.
	logic quiet      = 1'b0;
	int   n_inserts  = 0;
	int   n_removes  = 0;
	int   stall_left = 0;
	int   idle_run   = 0;

	linear_scan_priority_queue #(.CAPACITY(CAPACITY)) u_dut (.*);

	lsq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [PRIO_W-1:0] pick_prio(input prio_style_t style);
		case (style)
			PRIO_NARROW: return PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
			PRIO_EDGE: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_payload();
		case ($urandom_range(0, 19))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return 32'shffff_ffff;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Presents one transaction and returns at the edge that accepts it; valid stays up
	// so a back-to-back transaction needs no second assignment in that step.
	task automatic send_op(input lsq_mode_t op, input logic signed [PRIO_W-1:0] prio,
		input logic signed [DATA_W-1:0] data);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= op;
		priority_req <= prio;
		payload      <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == MODE_INSERT)
			n_inserts++;
		else
			n_removes++;
	endtask

	// The checker's pending count is registered, so wait for the next edge before looking at it.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (quiet || out_stall || $urandom_range(0, 99) < 55) begin
			out_stall  <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall  <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("[%0t] no transaction for %0d cycles, %0d results still pending",
					$realtime, idle_run, outstanding);
				$display("** linear_scan_priority_queue: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int burst_len;
		int insert_pct;
		prio_style_t style;
		lsq_mode_t op;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty remove, extreme fields, equal priorities, full queue, drain a few.
		send_op(MODE_REMOVE, 16'sh7fff, 32'sh7fff_ffff);
		send_op(MODE_INSERT, 16'sh7fff, 32'sh7fff_ffff);
		send_op(MODE_INSERT, 16'sh8000, 32'sh8000_0000);
		send_op(MODE_INSERT, 16'sh0000, 32'sh0000_0000);
		send_op(MODE_INSERT, 16'shffff, 32'shffff_ffff);
		send_op(MODE_INSERT, 16'sh7fff, 32'sh1234_5678);
		send_op(MODE_INSERT, 16'sh8000, 32'sh5555_aaaa);
		for (int i = 6; i < CAPACITY; i++)
			send_op(MODE_INSERT, 16'sh0005, DATA_W'(i));
		send_op(MODE_INSERT, 16'sh7fff, 32'shdead_beef);
		repeat (4)
			send_op(MODE_REMOVE, '0, '0);
		wait_until_drained();

		// Random bursts, each leaning toward inserts or removes so the fill level
		// sweeps between empty and full.
		sent = 0;
		while (sent < RANDOM_OPS) begin
			burst_len  = $urandom_range(20, 80);
			insert_pct = ($urandom_range(0, 1) == 0) ? $urandom_range(5, 35)
				: $urandom_range(55, 95);
			style      = prio_style_t'($urandom_range(0, 2));
			quiet      = ($urandom_range(0, 5) == 0);
			repeat (burst_len) begin
				op = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
				send_op(op, pick_prio(style), pick_payload());
				sent++;
			end
			if ($urandom_range(0, 5) == 0)
				wait_until_drained();
		end
		quiet = 1'b0;

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d inserts and %0d removes; checked %0d results, peak depth %0d.",
			n_inserts, n_removes, results_checked, peak_fill);
		$display("%0d inserts met a full queue, %0d removes met an empty one, %0d mismatches.",
			full_drops, empty_removes, mismatches);
		if (mismatches == 0)
			$display("** linear_scan_priority_queue: PASSED **");
		else
			$display("** linear_scan_priority_queue: FAILED **");
		$finish;
	end

endmodule
